// File: hdl/fwpid_pkg.sv
// Shared types and constants of the four-wheel PID speed controller.
`timescale 1ns / 1ps

package fwpid_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int SPEED_W    = 16;
   localparam int YAW_W      = 14;
   localparam int TARGET_W   = 10;
   localparam int GAIN_W     = 16;
   localparam int DRIVE_W    = 8;

   // Packed stream layouts.
   localparam int YAW_LSB    = NUM_WHEELS * SPEED_W;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = NUM_WHEELS * DRIVE_W;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_SPEED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAINS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAINS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DERIV_GAINS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDFWD_GAINS = 3'd4;
   localparam logic [TARGET_W-1:0]  TARGET_RESET      = 10'd100;

   // Item kinds.
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_RESET = 1'b1;

   // Control law limits in their fixed-point formats.
   localparam int ERR_GATE   = 240;     // 15 rpm in Q.4
   localparam int INTEG_LIM  = 1920;    // 60 in Q.5
   localparam int DRIVE_MAX  = 65280;   // 255.0 in Q8.8

   // Floor division by five through a reciprocal: exact for values below 2^18.
   localparam int DIV5_MUL   = 209716;
   localparam int DIV5_SHIFT = 20;
   localparam int STEP_BIAS  = 40960;   // makes the scaled delta non-negative

   typedef struct packed {
      logic start;
      logic mode;
   } lane_ctrl_type;

   typedef struct packed {
      logic               done;
      logic [DRIVE_W-1:0] drive;
   } lane_result_type;

endpackage

// File: hdl/fwpid_lane.sv
// One wheel's PID lane: error, integral, derivative, drive update and wheel state.
`timescale 1ns / 1ps

module fwpid_lane #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fwpid_pkg::lane_ctrl_type               ctrl,
   input  logic signed [fwpid_pkg::SPEED_W-1:0]   speed,
   input  logic signed [fwpid_pkg::YAW_W:0]       yaw,
   input  logic [fwpid_pkg::TARGET_W-1:0]         target,
   input  logic [fwpid_pkg::GAIN_W-1:0]           kp,
   input  logic [fwpid_pkg::GAIN_W-1:0]           ki,
   input  logic [fwpid_pkg::GAIN_W-1:0]           kd,
   input  logic [fwpid_pkg::GAIN_W-1:0]           kff,
   output fwpid_pkg::lane_result_type             result
);
   import fwpid_pkg::*;

   localparam int FB      = GAIN_FRAC_BITS + 5;
   localparam int ERR_W   = 17;
   localparam int INT_W   = 12;
   localparam int MAG_W   = 16;
   localparam int LVL_W   = 16;
   localparam int PROD_W  = 34;
   localparam int IPROD_W = 29;
   localparam int DRAW_W  = 40;
   localparam int PI_W    = 36;
   localparam int DCL_W   = GAIN_FRAC_BITS + 10;
   localparam int SUM_W   = 37;
   localparam int U_W     = 17;
   localparam int QUO_W   = 35;
   localparam int NEXT_W  = 18;
   localparam int FF_W    = GAIN_W + TARGET_W;
   localparam int FFS_W   = FF_W + 4;
   localparam int SHR     = GAIN_FRAC_BITS - 3;
   localparam int FF_RSH  = (GAIN_FRAC_BITS >= 8) ? GAIN_FRAC_BITS - 8 : 0;
   localparam int FF_LSH  = (GAIN_FRAC_BITS < 8) ? 8 - GAIN_FRAC_BITS : 0;
   localparam int STEP_OFF = STEP_BIAS / 5;

   localparam logic signed [ERR_W-1:0]  GATE_HI   = ERR_W'(ERR_GATE);
   localparam logic signed [INT_W:0]    INT_LIM   = (INT_W+1)'(INTEG_LIM);
   localparam logic signed [INT_W-1:0]  INT_HI    = INT_W'(INTEG_LIM);
   localparam logic signed [INT_W-1:0]  INT_LO    = INT_W'(-INTEG_LIM);
   localparam logic signed [DRAW_W-1:0] D_LIM     = DRAW_W'(10 << FB);
   localparam logic signed [SUM_W-1:0]  DELTA_LIM = SUM_W'(40 << FB);
   localparam logic signed [NEXT_W-1:0] NEXT_MAX  = NEXT_W'(DRIVE_MAX);

   // Wheel state.
   logic [LVL_W-1:0]        drive_ff, drive_in;
   logic signed [INT_W-1:0] integ_ff, integ_in;
   logic [MAG_W-1:0]        prev_ff, prev_in;

   // Stage valid bits and completion flag.
   logic [3:0] stage_v_ff, stage_v_in;
   logic       done_ff;

   // Stage 1 registers.
   logic                    mode1_ff;
   logic signed [ERR_W-1:0] err1_ff, err_in;
   logic signed [INT_W-1:0] integ1_ff, integ1_in;
   logic signed [ERR_W-1:0] diff1_ff, diff_in;
   logic [MAG_W-1:0]        mag1_ff, mag_in;
   logic [FF_W-1:0]         ffp1_ff, ffp_in;

   // Stage 2 registers.
   logic signed [PROD_W-1:0]  pprod2_ff, pprod_in;
   logic signed [IPROD_W-1:0] iprod2_ff, iprod_in;
   logic signed [PROD_W-1:0]  dprod2_ff, dprod_in;

   // Stage 3 and 4 registers.
   logic signed [DCL_W-1:0] dcl3_ff, dcl_in;
   logic signed [PI_W-1:0]  pi3_ff, pi_in;
   logic [U_W-1:0]          u4_ff, u_in;

   // Stage 0: error, gated integral, speed difference and feedforward product.
   logic signed [MAG_W:0]   speed_x, mag_x;
   logic                    gate;
   logic signed [INT_W:0]   integ_add, integ_sum;

   always_comb begin
      speed_x   = {speed[SPEED_W-1], speed};
      mag_x     = speed[SPEED_W-1] ? -speed_x : speed_x;
      mag_in    = mag_x[MAG_W-1:0];
      err_in    = $signed({3'b000, target, 4'b0000}) + ERR_W'(yaw)
                - $signed({1'b0, mag_in});
      gate      = (err_in > -GATE_HI) && (err_in < GATE_HI);
      integ_add = gate ? $signed(err_in[INT_W:0]) : '0;
      integ_sum = (INT_W+1)'(integ_ff) + integ_add;
      if (integ_sum > INT_LIM) begin
         integ1_in = INT_HI;
      end else if (integ_sum < -INT_LIM) begin
         integ1_in = INT_LO;
      end else begin
         integ1_in = integ_sum[INT_W-1:0];
      end
      diff_in   = $signed({1'b0, mag_in}) - $signed({1'b0, prev_ff});
      ffp_in    = FF_W'(kff) * FF_W'(target);
   end

   // Stage 1: the three gain products.
   always_comb begin
      pprod_in = $signed({1'b0, kp}) * err1_ff;
      iprod_in = $signed({1'b0, ki}) * integ1_ff;
      dprod_in = $signed({1'b0, kd}) * diff1_ff;
   end

   // Stage 2: derivative scaled by -40 and clamped, doubled P and I summed.
   logic signed [DRAW_W-1:0] dx, d_raw, d_sel;

   always_comb begin
      dx    = DRAW_W'(dprod2_ff);
      d_raw = -((dx <<< 5) + (dx <<< 3));
      if (d_raw > D_LIM) begin
         d_sel = D_LIM;
      end else if (d_raw < -D_LIM) begin
         d_sel = -D_LIM;
      end else begin
         d_sel = d_raw;
      end
      dcl_in = d_sel[DCL_W-1:0];
      pi_in  = (PI_W'(pprod2_ff) <<< 1) + PI_W'(iprod2_ff);
   end

   // Stage 3: delta clamp, scale by 4 / 2^(F-3) and bias for the divide by five.
   logic signed [SUM_W-1:0] delta_raw, delta_c, q_wide, u_wide;

   always_comb begin
      delta_raw = SUM_W'(pi3_ff) + SUM_W'(dcl3_ff);
      if (delta_raw > DELTA_LIM) begin
         delta_c = DELTA_LIM;
      end else if (delta_raw < -DELTA_LIM) begin
         delta_c = -DELTA_LIM;
      end else begin
         delta_c = delta_raw;
      end
      q_wide = (delta_c <<< 2) >>> SHR;
      u_wide = q_wide + SUM_W'(STEP_BIAS);
      u_in   = u_wide[U_W-1:0];
   end

   // Stage 4: drive update with saturation and anti-windup, or feedforward load.
   logic [QUO_W-1:0]         quo;
   logic signed [NEXT_W-1:0] next_lvl;
   logic [FFS_W-1:0]         ffs;
   logic [LVL_W-1:0]         ff_drive;

   always_comb begin
      quo      = QUO_W'(u4_ff) * QUO_W'(DIV5_MUL);
      next_lvl = $signed({2'b00, drive_ff}) + $signed({3'b000, quo[QUO_W-1:DIV5_SHIFT]})
               - NEXT_W'(STEP_OFF);
      ffs      = (FFS_W'(ffp1_ff) << FF_LSH) >> FF_RSH;
      ff_drive = (ffs > FFS_W'(DRIVE_MAX)) ? LVL_W'(DRIVE_MAX) : ffs[LVL_W-1:0];

      drive_in = drive_ff;
      integ_in = integ_ff;
      prev_in  = prev_ff;
      if (stage_v_ff[3]) begin
         if (mode1_ff == MODE_RESET) begin
            drive_in = ff_drive;
            integ_in = '0;
            prev_in  = '0;
         end else begin
            integ_in = integ1_ff;
            prev_in  = mag1_ff;
            if (next_lvl > NEXT_MAX) begin
               drive_in = LVL_W'(DRIVE_MAX);
               if (integ1_ff > 0) begin
                  integ_in = '0;
               end
            end else if (next_lvl[NEXT_W-1]) begin
               drive_in = '0;
               if (integ1_ff < 0) begin
                  integ_in = '0;
               end
            end else begin
               drive_in = next_lvl[LVL_W-1:0];
            end
         end
      end
      stage_v_in = {stage_v_ff[2:0], ctrl.start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff   <= '0;
         integ_ff   <= '0;
         prev_ff    <= '0;
         stage_v_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         drive_ff   <= drive_in;
         integ_ff   <= integ_in;
         prev_ff    <= prev_in;
         stage_v_ff <= stage_v_in;
         done_ff    <= stage_v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         mode1_ff  <= ctrl.mode;
         err1_ff   <= err_in;
         integ1_ff <= integ1_in;
         diff1_ff  <= diff_in;
         mag1_ff   <= mag_in;
         ffp1_ff   <= ffp_in;
      end
      if (stage_v_ff[0]) begin
         pprod2_ff <= pprod_in;
         iprod2_ff <= iprod_in;
         dprod2_ff <= dprod_in;
      end
      if (stage_v_ff[1]) begin
         dcl3_ff <= dcl_in;
         pi3_ff  <= pi_in;
      end
      if (stage_v_ff[2]) begin
         u4_ff <= u_in;
      end
   end

   assign result.done  = done_ff;
   assign result.drive = drive_ff[LVL_W-1 -: DRIVE_W];

   a_drive_limit: assert property (@(posedge clock) disable iff (reset)
      drive_ff <= LVL_W'(DRIVE_MAX))
      else $error("drive level above 255.0");

   a_integ_limit: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= INT_HI) && (integ_ff >= INT_LO))
      else $error("integral outside its clamp");

endmodule

// File: hdl/fwpid_merge.sv
// Output stage: gathers the four lane drives into one result item and holds it.
`timescale 1ns / 1ps

module fwpid_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  fwpid_pkg::lane_result_type          lane_res [fwpid_pkg::NUM_WHEELS],
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [fwpid_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                released
);
   import fwpid_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  pending_ff, pending_in;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  have, load;

   always_comb begin
      have       = lane_res[0].done || pending_ff;
      load       = have && (!valid_ff || rsp_tready);
      pending_in = have && !load;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
      data_in = data_ff;
      if (load) begin
         for (int i = 0; i < NUM_WHEELS; i++) begin
            data_in[i*DRIVE_W +: DRIVE_W] = lane_res[i].drive;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         pending_ff <= pending_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign released   = load;

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      (lane_res[0].done == lane_res[1].done) && (lane_res[0].done == lane_res[2].done)
      && (lane_res[0].done == lane_res[3].done))
      else $error("lanes finished in different cycles");

   a_pending_only_when_full: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> valid_ff)
      else $error("result held back although the output register was free");

endmodule

// File: hdl/four_wheel_pid_speed_controller.sv
// Top level of the four-wheel incremental PID speed controller.
`timescale 1ns / 1ps

// Each request item is one control tick for four wheels, or a controller reset
// when req_tuser is high. A tick runs one PID lane per wheel: the speed error
// against the target (plus yaw for wheels a and c, minus yaw for b and d), a
// half-weight integral that only moves while the error is under 15 rpm and is
// clamped to +/-60, a derivative on the speed magnitude clamped to +/-10, and a
// delta clamped to +/-40 of which 0.8 is added to the Q8.8 drive level. The
// level saturates at 0 and 255.0, and a saturation clears an integral of the
// same sign. A reset item loads each drive level from its feedforward gain times
// the target and clears the integral and previous speed. Every item produces
// exactly one response item with the four drive duties. An item passes through
// four register stages inside each lane (gated error, gain products, clamps,
// divide-by-five) and then the state update. The finished result is loaded into
// the output register once that register is free or being emptied. The next item
// starts in the cycle its predecessor's result enters that register, so the lanes
// take one item at a time, a limit set by the per-wheel drive and integral state
// that each tick hands to the next. A one-entry input buffer takes a new item
// while a result waits to be taken. Configuration registers may only be written
// while no item is in flight.
module four_wheel_pid_speed_controller #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata from bit 0: speed_a[15:0], speed_b[15:0], speed_c[15:0],
   // speed_d[15:0], yaw_offset[13:0], two zero pad bits.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [fwpid_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                  req_tuser,   // mode
   // rsp_tdata from bit 0: drive_a, drive_b, drive_c, drive_d, 8 bits each.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [fwpid_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                  csr_wen,
   input  logic [fwpid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fwpid_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import fwpid_pkg::*;

   // Configuration registers.
   logic [TARGET_W-1:0]   target_speed_ff;
   logic [CSR_DATA_W-1:0] prop_gains_ff;
   logic [CSR_DATA_W-1:0] integ_gains_ff;
   logic [CSR_DATA_W-1:0] deriv_gains_ff;
   logic [CSR_DATA_W-1:0] feedfwd_gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_speed_ff  <= TARGET_RESET;
         prop_gains_ff    <= '0;
         integ_gains_ff   <= '0;
         deriv_gains_ff   <= '0;
         feedfwd_gains_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            REG_TARGET_SPEED:  target_speed_ff  <= csr_wdata[TARGET_W-1:0];
            REG_PROP_GAINS:    prop_gains_ff    <= csr_wdata;
            REG_INTEG_GAINS:   integ_gains_ff   <= csr_wdata;
            REG_DERIV_GAINS:   deriv_gains_ff   <= csr_wdata;
            REG_FEEDFWD_GAINS: feedfwd_gains_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input buffer: holds one item until the lanes are free to take it.
   logic                      buf_valid_ff, buf_valid_in;
   logic                      buf_mode_ff;
   logic signed [SPEED_W-1:0] buf_speed_ff [NUM_WHEELS];
   logic signed [YAW_W-1:0]   buf_yaw_ff;
   logic                      busy_ff, busy_in;
   logic                      launch, released, req_take;

   assign launch     = buf_valid_ff && (!busy_ff || released);
   assign req_tready = !buf_valid_ff || launch;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         buf_valid_in = 1'b1;
      end else if (launch) begin
         buf_valid_in = 1'b0;
      end else begin
         buf_valid_in = buf_valid_ff;
      end
      if (launch) begin
         busy_in = 1'b1;
      end else if (released) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         busy_ff      <= busy_in;
      end
      if (req_take) begin
         buf_mode_ff <= req_tuser;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            buf_speed_ff[i] <= req_tdata[i*SPEED_W +: SPEED_W];
         end
         buf_yaw_ff <= req_tdata[YAW_LSB +: YAW_W];
      end
   end

   // Yaw correction is added for wheels a and c and subtracted for b and d.
   logic signed [YAW_W:0] yaw_pos, yaw_neg;
   assign yaw_pos = {buf_yaw_ff[YAW_W-1], buf_yaw_ff};
   assign yaw_neg = -yaw_pos;

   lane_ctrl_type   lane_ctrl;
   lane_result_type lane_res [NUM_WHEELS];

   assign lane_ctrl.start = launch;
   assign lane_ctrl.mode  = buf_mode_ff;

   for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_lane
      fwpid_lane #(
         .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .speed  (buf_speed_ff[i]),
         .yaw    ((i % 2 == 1) ? yaw_neg : yaw_pos),
         .target (target_speed_ff),
         .kp     (prop_gains_ff[i*GAIN_W +: GAIN_W]),
         .ki     (integ_gains_ff[i*GAIN_W +: GAIN_W]),
         .kd     (deriv_gains_ff[i*GAIN_W +: GAIN_W]),
         .kff    (feedfwd_gains_ff[i*GAIN_W +: GAIN_W]),
         .result (lane_res[i])
      );
   end

   fwpid_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_res   (lane_res),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .released   (released)
   );

   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      lane_res[0].done |-> busy_ff)
      else $error("lanes finished without an item in flight");

endmodule
